FILE: hw/rtl/sarm_pkg.sv
// Shared types, constants and arithmetic helpers for the spin axis rotation matrix unit.
// Used by the division cell, turn prep, CORDIC cell and the top level. No dependencies.
package sarm_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int SHIFT_W       = 5;
	localparam int TIME_W        = 56;
	localparam int NUM_W         = 93;   // 61-bit 24*t followed by 32 fraction bits
	localparam int DIV_STEPS     = NUM_W;
	localparam int REM_W         = 48;
	localparam int TURN_W        = 32;
	localparam int XY_W          = 34;
	localparam int Z_W           = 33;
	localparam int Q_W           = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int LAT           = 100 + CORDIC_STAGES;
	localparam int ANG_W         = 26;
	localparam int ANG_PROD_W    = 55;
	localparam int RECIP_SHIFT   = 33;

	// degrees to turn: u * 8192 / 45 = 182 * u + (2 * u) / 45
	localparam logic [TURN_W-1:0]        DEG_TURN_WHOLE = 32'd182;
	localparam logic [27:0]              RECIP_45    = 28'd190887436;
	localparam logic signed [XY_W-1:0]   CORDIC_GAIN = 34'sd652032874;
	localparam logic [30:0]              HALF_PI_Q30 = 31'd1686629713;
	localparam logic signed [Q_W-1:0]    ONE_Q30     = 32'sd1073741824;
	localparam logic signed [26:0]       COLAT_BASE  = 27'sd29491200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLE_LAT = 3'd0,
		REG_POLE_LON = 3'd1,
		REG_PERIOD   = 3'd2,
		REG_PHASE0   = 3'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [NUM_W-1:0]  num;
		logic [TURN_W-1:0] quo;
	} div_word_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		quad_t                  quad;
	} cordic_vec_t;

	// arctangent of 2^-i, Q2.30 radians
	function automatic logic signed [Z_W-1:0] atan_q30(input logic [SHIFT_W-1:0] idx);
		logic signed [Z_W-1:0] a;
		case (idx)
			5'd0:  a = 33'sh3243F6A8;
			5'd1:  a = 33'sh1DAC6705;
			5'd2:  a = 33'sh0FADBAFC;
			5'd3:  a = 33'sh07F56EA6;
			5'd4:  a = 33'sh03FEAB76;
			5'd5:  a = 33'sh01FFD55B;
			5'd6:  a = 33'sh00FFFAAA;
			5'd7:  a = 33'sh007FFF55;
			5'd8:  a = 33'sh003FFFEA;
			5'd9:  a = 33'sh001FFFFD;
			5'd10: a = 33'sh000FFFFF;
			5'd11: a = 33'sh0007FFFF;
			5'd12: a = 33'sh0003FFFF;
			5'd13: a = 33'sh0001FFFF;
			5'd14: a = 33'sh0000FFFF;
			5'd15: a = 33'sh00007FFF;
			5'd16: a = 33'sh00003FFF;
			5'd17: a = 33'sh00001FFF;
			5'd18: a = 33'sh00000FFF;
			5'd19: a = 33'sh000007FF;
			5'd20: a = 33'sh000003FF;
			5'd21: a = 33'sh000001FF;
			5'd22: a = 33'sh000000FF;
			5'd23: a = 33'sh0000007F;
			5'd24: a = 33'sh0000003F;
			5'd25: a = 33'sh0000001F;
			5'd26: a = 33'sh0000000F;
			5'd27: a = 33'sh00000008;
			5'd28: a = 33'sh00000004;
			5'd29: a = 33'sh00000002;
			5'd30: a = 33'sh00000001;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Q1.30 product, rounded with ties upward
	function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [63:0] p;
		p = a * b;
		p = p + 64'sd536870912;
		return Q_W'(p >>> 30);
	endfunction

	function automatic logic signed [Q_W-1:0] clamp_sum(input logic signed [Q_W:0] v);
		logic signed [Q_W-1:0] r;
		if (v > 33'sd1073741824)
			r = ONE_Q30;
		else if (v < -33'sd1073741824)
			r = -ONE_Q30;
		else
			r = Q_W'(v);
		return r;
	endfunction

	function automatic logic signed [Q_W-1:0] clamp_xy(input logic signed [XY_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > 34'sd1073741824)
			r = ONE_Q30;
		else if (v < -34'sd1073741824)
			r = -ONE_Q30;
		else
			r = Q_W'(v);
		return r;
	endfunction

endpackage

FILE: hw/rtl/sarm_div_cell.sv
// One restoring division step: shift in the next dividend bit, subtract if it fits.
// Depends on sarm_pkg for the word layout.
module sarm_div_cell import sarm_pkg::*; (
	input  logic             clk,
	input  logic [REM_W-1:0] dvsr,
	input  div_word_t        word_i,
	output div_word_t        word_o
);

	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic           take;
	div_word_t      word_q;

	always_comb begin
		trial = {word_i.rem, word_i.num[NUM_W-1]};
		diff  = trial - {1'b0, dvsr};
		take  = (trial >= {1'b0, dvsr});
	end

	always_ff @(posedge clk) begin
		word_q.rem <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
		word_q.num <= {word_i.num[NUM_W-2:0], 1'b0};
		word_q.quo <= {word_i.quo[TURN_W-2:0], take};
	end

	assign word_o = word_q;

endmodule

FILE: hw/rtl/sarm_turn_prep.sv
// Splits a 32-bit turn into quadrant and a Q2.30 radian residual, two stages.
// Depends on sarm_pkg; feeds the first CORDIC cell.
module sarm_turn_prep import sarm_pkg::*; (
	input  logic              clk,
	input  logic [TURN_W-1:0] turn,
	output cordic_vec_t       vec_o
);

	logic [TURN_W-1:0] tp;
	logic [29:0]       rl;
	logic [29:0]       mag;
	logic [60:0]       prod_s1;
	logic              neg_s1;
	quad_t             quad_s1;
	logic [30:0]       zm;
	logic signed [Z_W-1:0] zs;
	cordic_vec_t       vec_s2;

	always_comb begin
		tp  = turn + 32'h2000_0000;
		rl  = tp[29:0];
		mag = rl[29] ? {1'b0, rl[28:0]} : (30'h2000_0000 - rl);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 61'(mag) * 61'(HALF_PI_Q30);
		neg_s1  <= ~rl[29];
		quad_s1 <= quad_t'(tp[31:30]);
	end

	always_comb begin
		zm = 31'((prod_s1 + 61'h2000_0000) >> 30);
		zs = $signed({2'b00, zm});
	end

	always_ff @(posedge clk) begin
		vec_s2.x    <= CORDIC_GAIN;
		vec_s2.y    <= '0;
		vec_s2.z    <= neg_s1 ? -zs : zs;
		vec_s2.quad <= quad_s1;
	end

	assign vec_o = vec_s2;

endmodule

FILE: hw/rtl/sarm_cordic_cell.sv
// One rotation-mode CORDIC iteration with its output register.
// Depends on sarm_pkg for the vector type and arctangent table.
module sarm_cordic_cell import sarm_pkg::*; (
	input  logic               clk,
	input  logic [SHIFT_W-1:0] idx,
	input  cordic_vec_t        vec_i,
	output cordic_vec_t        vec_o
);

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  ang;
	cordic_vec_t            nxt;
	cordic_vec_t            vec_q;

	always_comb begin
		xs  = vec_i.x >>> idx;
		ys  = vec_i.y >>> idx;
		ang = atan_q30(idx);
		nxt.quad = vec_i.quad;
		if (!vec_i.z[Z_W-1]) begin
			nxt.x = vec_i.x - ys;
			nxt.y = vec_i.y + xs;
			nxt.z = vec_i.z - ang;
		end else begin
			nxt.x = vec_i.x + ys;
			nxt.y = vec_i.y - xs;
			nxt.z = vec_i.z + ang;
		end
	end

	always_ff @(posedge clk) begin
		vec_q <= nxt;
	end

	assign vec_o = vec_q;

endmodule

FILE: hw/rtl/spin_axis_rotation_matrix_unit.sv
// The path from accepted start to done runs through the 93-cell restoring division chain
// and the CORDIC cell chain.
// Throughput: one observation time per cycle; busy stays low and done cannot be held off.
// Reset clears the configuration registers to their defaults and drops words in flight.
// Depends on sarm_pkg, sarm_div_cell, sarm_turn_prep and sarm_cordic_cell.
module spin_axis_rotation_matrix_unit import sarm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [TIME_W-1:0]     time_days,
	output logic                  done,
	output logic signed [Q_W-1:0] m00,
	output logic signed [Q_W-1:0] m01,
	output logic signed [Q_W-1:0] m02,
	output logic signed [Q_W-1:0] m10,
	output logic signed [Q_W-1:0] m11,
	output logic signed [Q_W-1:0] m12,
	output logic signed [Q_W-1:0] m20,
	output logic signed [Q_W-1:0] m21,
	output logic signed [Q_W-1:0] m22,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CH_PHASE0 = 0;
	localparam int CH_COLAT  = 1;
	localparam int CH_LON    = 2;

	logic signed [23:0] pole_lat_q;
	logic [24:0]        pole_lon_q;
	logic [31:0]        period_q;
	logic [24:0]        phase0_q;
	logic               accept;
	logic [LAT-1:0]     vld_q;

	logic [60:0]        t24;
	logic signed [26:0] colat_s;
	logic [NUM_W-1:0]   num_in;
	logic [REM_W-1:0]   dvsr;
	div_word_t          dw [0:DIV_STEPS];

	logic [ANG_W-1:0]      ang_u       [0:2];
	logic [TURN_W-1:0]     ang_whole_q [0:2];
	logic [ANG_PROD_W-1:0] ang_prod_q  [0:2];
	logic [TURN_W-1:0]     ang_turn_q  [0:2];

	logic [TURN_W-1:0]  turn_s1 [0:2];
	cordic_vec_t        cv      [0:2][0:CORDIC_STAGES];
	logic signed [Q_W-1:0] cos_c [0:2];
	logic signed [Q_W-1:0] sin_c [0:2];
	logic signed [Q_W-1:0] cos_s2 [0:2];
	logic signed [Q_W-1:0] sin_s2 [0:2];

	logic signed [Q_W-1:0] cbcl_s3, cbsl_s3, cfsb_s3, sfsb_s3, sbcl_s3, sbsl_s3;
	logic signed [Q_W-1:0] cfsl_s3, sfsl_s3, cfcl_s3, sfcl_s3, cf_s3, sf_s3, cb_s3;
	logic signed [Q_W-1:0] cfcbcl_s4, cfcbsl_s4, sfcbcl_s4, sfcbsl_s4;
	logic signed [Q_W-1:0] cfsl_s4, sfsl_s4, cfcl_s4, sfcl_s4, cfsb_s4, sfsb_s4;
	logic signed [Q_W-1:0] sbcl_s4, sbsl_s4, cb_s4;

	assign accept    = start & ~busy;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_lat_q <= '0;
			pole_lon_q <= '0;
			period_q   <= 32'd1572864;
			phase0_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POLE_LAT: pole_lat_q <= $signed(cfg_data[23:0]);
				REG_POLE_LON: pole_lon_q <= cfg_data[24:0];
				REG_PERIOD:   period_q   <= cfg_data;
				REG_PHASE0:   phase0_q   <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// Dividend: 24*t with 32 fraction bits over the period in 1/65536 s of an hour
	always_comb begin
		t24     = 61'({time_days, 4'b0}) + 61'({time_days, 3'b0});
		colat_s = COLAT_BASE - 27'(pole_lat_q);
		num_in  = {t24, 32'b0};
		dvsr    = {period_q, 16'b0};
		ang_u[CH_PHASE0] = ANG_W'(phase0_q);
		ang_u[CH_COLAT]  = colat_s[ANG_W-1:0];
		ang_u[CH_LON]    = ANG_W'(pole_lon_q);
	end

	assign dw[0].rem = '0;
	assign dw[0].num = num_in;
	assign dw[0].quo = '0;
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_cell
		sarm_div_cell u_cell (
			.clk    (clk),
			.dvsr   (dvsr),
			.word_i (dw[j]),
			.word_o (dw[j+1])
		);
	end

	// The user must hold the angle registers still while words are in flight; the block does not enforce it.
	// ang_whole_q and ang_prod_q, then ang_turn_q, settle the turn long before a word leaves the division chain
	for (genvar a = 0; a < 3; a++) begin : g_deg
		always_ff @(posedge clk) begin
			ang_whole_q[a] <= TURN_W'(ang_u[a]) * DEG_TURN_WHOLE;
			ang_prod_q[a]  <= ANG_PROD_W'({ang_u[a], 1'b0}) * ANG_PROD_W'(RECIP_45);
			ang_turn_q[a]  <= ang_whole_q[a] + TURN_W'(ang_prod_q[a] >> RECIP_SHIFT);
		end
	end

	// A zero period leaves no time term
	always_ff @(posedge clk) begin
		turn_s1[0] <= ((period_q == '0) ? '0 : dw[DIV_STEPS].quo)
			+ ang_turn_q[CH_PHASE0];
		turn_s1[1] <= ang_turn_q[CH_COLAT];
		turn_s1[2] <= ang_turn_q[CH_LON];
	end

	for (genvar a = 0; a < 3; a++) begin : g_ang
		sarm_turn_prep u_prep (
			.clk   (clk),
			.turn  (turn_s1[a]),
			.vec_o (cv[a][0])
		);
		for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
			sarm_cordic_cell u_cell (
				.clk   (clk),
				.idx   (SHIFT_W'(j)),
				.vec_i (cv[a][j]),
				.vec_o (cv[a][j+1])
			);
		end

		// fold the quadrant back in
		always_comb begin
			case (cv[a][CORDIC_STAGES].quad)
				QUAD_0: begin
					cos_c[a] = clamp_xy(cv[a][CORDIC_STAGES].x);
					sin_c[a] = clamp_xy(cv[a][CORDIC_STAGES].y);
				end
				QUAD_90: begin
					cos_c[a] = clamp_xy(-cv[a][CORDIC_STAGES].y);
					sin_c[a] = clamp_xy(cv[a][CORDIC_STAGES].x);
				end
				QUAD_180: begin
					cos_c[a] = clamp_xy(-cv[a][CORDIC_STAGES].x);
					sin_c[a] = clamp_xy(-cv[a][CORDIC_STAGES].y);
				end
				default: begin
					cos_c[a] = clamp_xy(cv[a][CORDIC_STAGES].y);
					sin_c[a] = clamp_xy(-cv[a][CORDIC_STAGES].x);
				end
			endcase
		end

		always_ff @(posedge clk) begin
			cos_s2[a] <= cos_c[a];
			sin_s2[a] <= sin_c[a];
		end
	end

	// index 0: phase f, 1: colatitude b, 2: longitude l
	always_ff @(posedge clk) begin
		cbcl_s3 <= qmul(cos_s2[1], cos_s2[2]);
		cbsl_s3 <= qmul(cos_s2[1], sin_s2[2]);
		cfsb_s3 <= qmul(cos_s2[0], sin_s2[1]);
		sfsb_s3 <= qmul(sin_s2[0], sin_s2[1]);
		sbcl_s3 <= qmul(sin_s2[1], cos_s2[2]);
		sbsl_s3 <= qmul(sin_s2[1], sin_s2[2]);
		cfsl_s3 <= qmul(cos_s2[0], sin_s2[2]);
		sfsl_s3 <= qmul(sin_s2[0], sin_s2[2]);
		cfcl_s3 <= qmul(cos_s2[0], cos_s2[2]);
		sfcl_s3 <= qmul(sin_s2[0], cos_s2[2]);
		cf_s3   <= cos_s2[0];
		sf_s3   <= sin_s2[0];
		cb_s3   <= cos_s2[1];
	end

	always_ff @(posedge clk) begin
		cfcbcl_s4 <= qmul(cf_s3, cbcl_s3);
		cfcbsl_s4 <= qmul(cf_s3, cbsl_s3);
		sfcbcl_s4 <= qmul(sf_s3, cbcl_s3);
		sfcbsl_s4 <= qmul(sf_s3, cbsl_s3);
		cfsl_s4   <= cfsl_s3;
		sfsl_s4   <= sfsl_s3;
		cfcl_s4   <= cfcl_s3;
		sfcl_s4   <= sfcl_s3;
		cfsb_s4   <= cfsb_s3;
		sfsb_s4   <= sfsb_s3;
		sbcl_s4   <= sbcl_s3;
		sbsl_s4   <= sbsl_s3;
		cb_s4     <= cb_s3;
	end

	always_ff @(posedge clk) begin
		m00 <= clamp_sum(33'(cfcbcl_s4) - 33'(sfsl_s4));
		m01 <= clamp_sum(33'(cfcbsl_s4) + 33'(sfcl_s4));
		m02 <= clamp_sum(-33'(cfsb_s4));
		m10 <= clamp_sum(-33'(sfcbcl_s4) - 33'(cfsl_s4));
		m11 <= clamp_sum(33'(cfcl_s4) - 33'(sfcbsl_s4));
		m12 <= clamp_sum(33'(sfsb_s4));
		m20 <= clamp_sum(33'(sbcl_s4));
		m21 <= clamp_sum(33'(sbsl_s4));
		m22 <= clamp_sum(33'(cb_s4));
	end

	assign done = vld_q[LAT-1];

`ifndef ASSERT_OFF
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted word did not complete on time");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("done without a matching start");

	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (m00 <= ONE_Q30 && m00 >= -ONE_Q30 && m11 <= ONE_Q30
			&& m11 >= -ONE_Q30 && m22 <= ONE_Q30 && m22 >= -ONE_Q30))
		else $error("matrix entry outside unit range");
`endif

endmodule

FILE: bench/tb_spin_axis_rotation_matrix_unit.sv
// Self-checking bench for spin_axis_rotation_matrix_unit: drives observation times and
// configuration writes, and predicts every matrix word in fixed point. Depends on sarm_pkg.
module tb_spin_axis_rotation_matrix_unit import sarm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int       HOLD_LIMIT = 1000;
	localparam longint   DEG_FULL   = 64'd23592960;
	localparam longint   DEG_QUART  = 64'd5898240;
	localparam longint   Q30_ONE    = 64'sd1073741824;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [TIME_W-1:0]     time_days = '0;
	logic                  done;
	logic signed [Q_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	typedef logic [8:0][31:0] matrix_t;

	matrix_t      matrix_q[$];
	int           errors = 0;
	int           quiet_cycles = 0;
	bit           gaps_on = 1'b1;
	logic [23:0]  pole_lat_r;
	logic [24:0]  pole_lon_r;
	logic [31:0]  period_r;
	logic [24:0]  phase0_r;

	spin_axis_rotation_matrix_unit dut (.*);

	always #5 clk = ~clk;

	// ---------------- prediction ----------------
	function automatic longint unsigned angle_turn(input longint unsigned u);
		return ((u << 32) / DEG_FULL) & 64'hFFFF_FFFF;
	endfunction

	function automatic longint clamp_q30(input longint v);
		if (v > Q30_ONE)
			return Q30_ONE;
		if (v < -Q30_ONE)
			return -Q30_ONE;
		return v;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic longint atan_entry(input int i);
		longint tbl[32] = '{
			32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
			32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
			32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
			32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
			32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
			32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
			32'h00000001, 32'h00000000};
		return tbl[i];
	endfunction

	function automatic void turn_sincos(input longint unsigned turn, output longint c,
			output longint s);
		longint unsigned q, mag;
		longint          r, z, x, y, nx;
		q = ((turn + (64'd1 << 29)) >> 30) & 3;
		r = longint'((turn + (64'd1 << 29)) & ((64'd1 << 30) - 1)) - (64'sd1 << 29);
		mag = (r < 0) ? -r : r;
		z = longint'((mag * 64'd1686629713 + (64'd1 << 29)) >> 30);
		if (r < 0)
			z = -z;
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - longint'(atan_entry(i));
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + longint'(atan_entry(i));
			end
			x = nx;
		end
		case (quad_t'(q[1:0]))
			QUAD_0:   begin c = x;  s = y;  end
			QUAD_90:  begin c = -y; s = x;  end
			QUAD_180: begin c = -x; s = -y; end
			default:  begin c = y;  s = -x; end
		endcase
		c = clamp_q30(c);
		s = clamp_q30(s);
	endfunction

	// fraction of a turn covered by the spin since time zero
	function automatic longint unsigned spin_turn(input logic [TIME_W-1:0] t);
		longint unsigned d, rem, q;
		d = longint'(period_r) << 16;
		if (d == 0)
			return 0;
		rem = (64'd24 * longint'(t)) % d;
		q = 0;
		for (int i = 0; i < 32; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= d) begin
				rem = rem - d;
				q = q | 1;
			end
		end
		return q & 64'hFFFF_FFFF;
	endfunction

	function automatic matrix_t body_matrix(input logic [TIME_W-1:0] t);
		longint          cf, sf, cb, sb, cl, sl, cbcl, cbsl, lat;
		longint          m[9];
		longint unsigned phase;
		matrix_t         res;
		lat = longint'(signed'(pole_lat_r));
		phase = (spin_turn(t) + angle_turn(phase0_r)) & 64'hFFFF_FFFF;
		turn_sincos(phase, cf, sf);
		turn_sincos(angle_turn(longint'(DEG_QUART - lat + DEG_FULL)), cb, sb);
		turn_sincos(angle_turn(pole_lon_r), cl, sl);
		cbcl = fx_mul(cb, cl);
		cbsl = fx_mul(cb, sl);
		m[0] = clamp_q30(fx_mul(cf, cbcl) - fx_mul(sf, sl));
		m[1] = clamp_q30(fx_mul(cf, cbsl) + fx_mul(sf, cl));
		m[2] = clamp_q30(-fx_mul(cf, sb));
		m[3] = clamp_q30(-fx_mul(sf, cbcl) - fx_mul(cf, sl));
		m[4] = clamp_q30(fx_mul(cf, cl) - fx_mul(sf, cbsl));
		m[5] = clamp_q30(fx_mul(sf, sb));
		m[6] = clamp_q30(fx_mul(sb, cl));
		m[7] = clamp_q30(fx_mul(sb, sl));
		m[8] = clamp_q30(cb);
		for (int k = 0; k < 9; k++)
			res[k] = m[k][31:0];
		return res;
	endfunction

	// ---------------- drivers ----------------
	task automatic idle_burst();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic send_time(input logic [TIME_W-1:0] t);
		idle_burst();
		start <= 1'b1;
		time_days <= t;
		do @(posedge clk); while (busy);
		matrix_q = {matrix_q, body_matrix(t)};
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (matrix_q.size() != 0)
			@(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_POLE_LAT: pole_lat_r = val[23:0];
			REG_POLE_LON: pole_lon_r = val[24:0];
			REG_PERIOD:   period_r = val;
			REG_PHASE0:   phase0_r = val[24:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] lat, input logic [31:0] lon,
			input logic [31:0] per, input logic [31:0] ph);
		write_reg(REG_POLE_LAT, lat);
		write_reg(REG_POLE_LON, lon);
		write_reg(REG_PERIOD, per);
		write_reg(REG_PHASE0, ph);
		@(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return TIME_W'(w[31:0]);
			1: return TIME_W'(w[43:0]);
			default: return w[TIME_W-1:0];
		endcase
	endfunction

	// ---------------- checking ----------------
	always @(posedge clk) begin
		matrix_t got, want;
		got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
		if (done) begin
			if (matrix_q.size() == 0) begin
				$display("%0t: result word with nothing expected", $time);
				errors++;
			end else begin
				want = matrix_q.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== want[k]) begin
						$display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
							$signed(want[k]), $signed(got[k]));
						errors++;
					end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= HOLD_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ---------------- tests ----------------
	task automatic test_reset_defaults();
		logic [TIME_W-1:0] pts[12] = '{56'd0, 56'd1, 56'd2, 56'h1_0000_0000, 56'h8000_0000,
			{TIME_W{1'b1}}, 56'h80_0000_0000_0000, 56'h55_5555_5555_5555,
			56'hAA_AAAA_AAAA_AAAA, 56'h4000_0000, 56'hC000_0000, 56'h7F_FFFF_FFFF_FFFF};
		foreach (pts[i])
			send_time(pts[i]);
		drain();
	endtask

	task automatic test_register_extremes();
		// poles at both ends, zero period, shortest and longest period, wrapped angles
		write_all(32'd5898240, 32'd0, 32'd1, 32'd0);
		send_time(56'd0); send_time({TIME_W{1'b1}}); send_time(56'd12345);
		drain();
		write_all(-32'sd5898240, 32'd23592960, 32'hFFFF_FFFF, 32'd23592960);
		send_time(56'd0); send_time({TIME_W{1'b1}}); send_time(56'h12_3456_789A_BCDE);
		drain();
		write_all(32'd0, 32'd11796480, 32'd0, 32'd5898240);
		send_time(56'd777); send_time({TIME_W{1'b1}});
		drain();
		// raw bits beyond the ranges; spare register indexes do nothing
		write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		for (int i = int'(REG_PHASE0) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), $urandom);
		send_time(56'd5); send_time(56'hFF_0000_0000_0000);
		drain();
	endtask

	task automatic test_random_streams();
		logic [31:0] lat, per;
		for (int p = 0; p < 8; p++) begin
			gaps_on = (p < 6);
			lat = ($urandom_range(0, 7) == 0) ? $urandom
				: 32'($signed($urandom_range(0, 11796480)) - 5898240);
			case ($urandom_range(0, 3))
				0: per = $urandom_range(1, 4096);
				1: per = $urandom;
				default: per = $urandom_range(65536, 65536 * 1000);
			endcase
			write_all(lat, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 23592960),
				per, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 23592960));
			repeat (100)
				send_time(rand_time());
			drain();
		end
	endtask

	initial begin
		pole_lat_r = '0;
		pole_lon_r = '0;
		period_r = 32'd1572864;
		phase0_r = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_streams();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
